// ===== hdl/glpc_pkg.sv =====
package glpc_pkg;

    // widths of the stream fields and the ratio registers
    localparam int PIX_W   = 8;
    localparam int RATIO_W = 10;
    localparam int RATIO_N = 5;
    localparam int IDX_W   = 3;

    typedef logic [PIX_W-1:0]          t_pix;
    typedef logic signed [RATIO_W-1:0] t_ratio;
    typedef logic [IDX_W-1:0]          t_idx;

    // register indexes on the write port
    localparam t_idx IDX_RATIO_0   = 3'd0;
    localparam t_idx IDX_RATIO_32  = 3'd1;
    localparam t_idx IDX_RATIO_64  = 3'd2;
    localparam t_idx IDX_RATIO_192 = 3'd3;
    localparam t_idx IDX_RATIO_255 = 3'd4;

    // gray segments between the fixed breakpoints
    typedef enum logic [1:0] {
        SEG_LOW  = 2'd0,   // 0..31
        SEG_MID  = 2'd1,   // 32..63
        SEG_WIDE = 2'd2,   // 64..191
        SEG_TOP  = 2'd3    // 192..255
    } t_seg;

    localparam t_pix GRAY_32  = 8'd32;
    localparam t_pix GRAY_64  = 8'd64;
    localparam t_pix GRAY_192 = 8'd192;

    // datapath widths
    localparam int BASE_W = 18;   // ratio times segment length
    localparam int OFF_W  = 7;    // offset into segment
    localparam int DIFF_W = 11;   // ratio slope
    localparam int NUM_W  = 19;   // interpolated numerator, signed
    localparam int MAG_W  = 18;
    localparam int PROD_W = 26;   // |num| * g
    localparam int X_W    = 20;   // product after the power-of-two part of the divisor
    localparam int Q_W    = 19;
    localparam int DIV_SHIFT = 20;
    localparam int RECIP_W   = 19;
    localparam int MUL_W     = X_W + RECIP_W;
    localparam int SUM_W     = 21;

    // divisor D*192 split into power of two and odd factor
    // D=32: 2^11 * 3, D=128: 2^13 * 3, D=63: 2^6 * 189
    localparam int SH_NARROW = 11;
    localparam int SH_WIDE   = 13;
    localparam int SH_TOP    = 6;
    localparam logic [7:0] ODD_3   = 8'd3;
    localparam logic [7:0] ODD_189 = 8'd189;
    localparam logic [RECIP_W-1:0] RECIP_BY_3   = RECIP_W'((2**DIV_SHIFT) / 3);
    localparam logic [RECIP_W-1:0] RECIP_BY_189 = RECIP_W'((2**DIV_SHIFT) / 189);

    localparam t_pix PIX_MAX = 8'd255;

endpackage

// ===== hdl/gray_level_pixel_compensation.sv =====
// throughput: one pixel per clock while the output is not held, six register stages with a shared stall
// the only multi-cycle path is the reciprocal divide, split over two stages
// reset (i_rst_n low, synchronous) clears all ratios to zero and empties the pipeline
module gray_level_pixel_compensation (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  glpc_pkg::t_idx        i_cfg_index,
    input  glpc_pkg::t_ratio      i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  glpc_pkg::t_pix        i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output glpc_pkg::t_pix        o_pixel_out,
    output logic                  o_clamped
);
    import glpc_pkg::*;

    // ratio registers
    t_ratio r_ratio [RATIO_N];

    // pipeline advance: everything moves unless the output is held
    logic en;
    assign o_stall = o_valid & i_stall;
    assign en      = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RATIO_N; k++) begin
                r_ratio[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                IDX_RATIO_0:   r_ratio[0] <= i_cfg_data;
                IDX_RATIO_32:  r_ratio[1] <= i_cfg_data;
                IDX_RATIO_64:  r_ratio[2] <= i_cfg_data;
                IDX_RATIO_192: r_ratio[3] <= i_cfg_data;
                IDX_RATIO_255: r_ratio[4] <= i_cfg_data;
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // stage 1: segment, end ratios, base term and slope
    t_seg                     n_seg;
    t_ratio                   lo_ratio, hi_ratio;
    logic signed [BASE_W-1:0] n_base;
    logic [OFF_W-1:0]         n_off;
    logic signed [DIFF_W-1:0] n_diff;

    always_comb begin
        if (i_pixel_in < GRAY_32) begin
            n_seg = SEG_LOW;
        end else if (i_pixel_in < GRAY_64) begin
            n_seg = SEG_MID;
        end else if (i_pixel_in < GRAY_192) begin
            n_seg = SEG_WIDE;
        end else begin
            n_seg = SEG_TOP;
        end

        unique case (n_seg)
            SEG_LOW: begin
                lo_ratio = r_ratio[0];
                hi_ratio = r_ratio[1];
                n_off    = {2'b00, i_pixel_in[4:0]};
                n_base   = BASE_W'(lo_ratio) <<< 5;
            end
            SEG_MID: begin
                lo_ratio = r_ratio[1];
                hi_ratio = r_ratio[2];
                n_off    = {2'b00, i_pixel_in[4:0]};
                n_base   = BASE_W'(lo_ratio) <<< 5;
            end
            SEG_WIDE: begin
                lo_ratio = r_ratio[2];
                hi_ratio = r_ratio[3];
                n_off    = OFF_W'(i_pixel_in - GRAY_64);
                n_base   = BASE_W'(lo_ratio) <<< 7;
            end
            default: begin
                // top segment is 63 wide, so base is r*64 - r
                lo_ratio = r_ratio[3];
                hi_ratio = r_ratio[4];
                n_off    = {1'b0, i_pixel_in[5:0]};
                n_base   = (BASE_W'(lo_ratio) <<< 6) - BASE_W'(lo_ratio);
            end
        endcase
        n_diff = DIFF_W'(hi_ratio) - DIFF_W'(lo_ratio);
    end

    logic                     r_v1;
    t_pix                     r_g1;
    t_seg                     r_seg1;
    logic signed [BASE_W-1:0] r_base1;
    logic [OFF_W-1:0]         r_off1;
    logic signed [DIFF_W-1:0] r_diff1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1    <= i_pixel_in;
            r_seg1  <= n_seg;
            r_base1 <= n_base;
            r_off1  <= n_off;
            r_diff1 <= n_diff;
        end
    end

    // stage 2: interpolated numerator num = r_i*D + off*slope
    logic signed [NUM_W-1:0] n_num;
    assign n_num = NUM_W'(r_base1)
                 + NUM_W'($signed({1'b0, r_off1})) * NUM_W'(r_diff1);

    logic                    r_v2;
    t_pix                    r_g2;
    t_seg                    r_seg2;
    logic signed [NUM_W-1:0] r_num2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g2   <= r_g1;
            r_seg2 <= r_seg1;
            r_num2 <= n_num;
        end
    end

    // stage 3: magnitude of num times g, sign kept aside for truncation toward zero
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] n_prod;
    assign mag    = r_num2[NUM_W-1] ? MAG_W'(-r_num2) : MAG_W'(r_num2);
    assign n_prod = PROD_W'(mag) * PROD_W'(r_g2);

    logic              r_v3;
    t_pix              r_g3;
    t_seg              r_seg3;
    logic              r_neg3;
    logic [PROD_W-1:0] r_prod3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g3    <= r_g2;
            r_seg3  <= r_seg2;
            r_neg3  <= r_num2[NUM_W-1];
            r_prod3 <= n_prod;
        end
    end

    // stage 4: drop power-of-two factor, multiply by reciprocal of the odd factor
    logic [X_W-1:0]     n_x;
    logic [RECIP_W-1:0] recip;
    logic [7:0]         n_odd;
    logic [MUL_W-1:0]   n_mul;

    always_comb begin
        unique case (r_seg3)
            SEG_LOW, SEG_MID: begin
                n_x   = X_W'(r_prod3 >> SH_NARROW);
                recip = RECIP_BY_3;
                n_odd = ODD_3;
            end
            SEG_WIDE: begin
                n_x   = X_W'(r_prod3 >> SH_WIDE);
                recip = RECIP_BY_3;
                n_odd = ODD_3;
            end
            default: begin
                n_x   = X_W'(r_prod3 >> SH_TOP);
                recip = RECIP_BY_189;
                n_odd = ODD_189;
            end
        endcase
        n_mul = MUL_W'(n_x) * MUL_W'(recip);
    end

    logic             r_v4;
    t_pix             r_g4;
    logic             r_neg4;
    logic [X_W-1:0]   r_x4;
    logic [7:0]       r_odd4;
    logic [MUL_W-1:0] r_mul4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g4   <= r_g3;
            r_neg4 <= r_neg3;
            r_x4   <= n_x;
            r_odd4 <= n_odd;
            r_mul4 <= n_mul;
        end
    end

    // stage 5: estimate is exact or one short, fix with one remainder compare
    localparam int QM_W = Q_W + 8;
    logic [Q_W-1:0]  q_est;
    logic [QM_W-1:0] qm;
    logic [QM_W-1:0] rem;
    logic [Q_W-1:0]  n_q;

    assign q_est = r_mul4[MUL_W-1 -: Q_W];
    assign qm    = QM_W'(q_est) * QM_W'(r_odd4);
    assign rem   = QM_W'(r_x4) - qm;
    assign n_q   = (rem >= QM_W'(r_odd4)) ? q_est + Q_W'(1) : q_est;

    logic           r_v5;
    t_pix           r_g5;
    logic           r_neg5;
    logic [Q_W-1:0] r_q5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g5   <= r_g4;
            r_neg5 <= r_neg4;
            r_q5   <= n_q;
        end
    end

    // stage 6: apply correction with its sign, add to g, clamp to the pixel range
    logic signed [SUM_W-1:0] corr;
    logic signed [SUM_W-1:0] sum;
    t_pix                    n_pix;
    logic                    n_clamp;

    always_comb begin
        corr = r_neg5 ? -$signed(SUM_W'(r_q5)) : $signed(SUM_W'(r_q5));
        sum  = $signed(SUM_W'(r_g5)) + corr;
        if (sum < 0) begin
            n_pix   = '0;
            n_clamp = 1'b1;
        end else if (sum > $signed(SUM_W'(PIX_MAX))) begin
            n_pix   = PIX_MAX;
            n_clamp = 1'b1;
        end else begin
            n_pix   = PIX_W'(sum);
            n_clamp = 1'b0;
        end
    end

    logic r_v6;
    t_pix r_pix6;
    logic r_clamp6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix6   <= n_pix;
            r_clamp6 <= n_clamp;
        end
    end

    assign o_valid     = r_v6;
    assign o_pixel_out = r_pix6;
    assign o_clamped   = r_clamp6;

endmodule

// ===== tb/sv/tb_gray_level_pixel_compensation.sv =====
module tb_gray_level_pixel_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    import glpc_pkg::*;

    // run length and pacing
    localparam int     CYCLE_LIMIT   = 200000;   // watchdog, many times the slowest legal run
    localparam int     PIPE_SETTLE   = 8;        // six register stages plus margin
    localparam int     HOLD_LEN      = 80;       // long receiver hold-off, fills the pipe
    localparam int     HOLD_FIRST    = 120;      // result count that triggers the first hold-off
    localparam int     HOLD_STEP     = 260;
    localparam int     RAND_PHASES   = 10;
    localparam int     PHASE_ITEMS   = 65;
    localparam longint CORR_DIV      = 192;      // divisor of the correction term
    localparam t_ratio RATIO_TOP     = t_ratio'(511);
    localparam t_ratio RATIO_BOTTOM  = t_ratio'(-512);
    localparam t_idx   IDX_LAST      = '1;       // highest index the port can carry

    // one compensated pixel as the block should present it
    typedef struct packed {
        t_pix pixel;
        logic clamped;
    } t_compensated;

    // kinds of ratio setting applied between phases
    typedef enum int {
        SET_RANDOM,
        SET_GENTLE,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_ALTERNATE
    } t_setting;

    // receiver back-pressure patterns
    typedef enum int {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_TOGGLE
    } t_drain;

    // dut ports, the inputs all known from time zero
    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_cfg_we    = 1'b0;
    t_idx   i_cfg_index = '0;
    t_ratio i_cfg_data  = '0;
    logic   i_valid     = 1'b0;
    logic   o_stall;
    t_pix   i_pixel_in  = '0;
    logic   o_valid;
    logic   i_stall     = 1'b0;
    t_pix   o_pixel_out;
    logic   o_clamped;

    // shadow of the ratio registers as the block should hold them
    t_ratio ratio_now [RATIO_N];

    // pixels waiting to be offered, and compensated pixels still owed by the block
    t_pix         pending_pixels [$];
    t_compensated expected_pixels [$];

    // bookkeeping shared between the clocked processes
    logic   in_taken        = 1'b0;   // a request was accepted at the last rising edge
    int     cycle_count     = 0;
    int     accepted_count  = 0;
    int     results_seen    = 0;
    int     error_count     = 0;
    int     clamp_high_seen = 0;
    int     clamp_low_seen  = 0;
    int     settings_used   = 0;
    int     burst_left      = 1;
    int     gap_left        = 0;
    int     rx_cycle        = 0;
    int     hold_left       = 0;
    int     next_hold_mark  = HOLD_FIRST;
    t_drain drain_mode      = DRAIN_FREE;

    gray_level_pixel_compensation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_clamped   (o_clamped)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // piecewise-linear compensation of one pixel against the shadow ratios
    function automatic t_compensated compensate_pixel(input t_pix g);
        t_compensated res;
        t_seg         seg;
        longint       gv;
        longint       seg_start;
        longint       seg_len;
        longint       r_lo;
        longint       r_hi;
        longint       num;
        longint       total;
        gv = g;
        if (g < GRAY_32) begin
            seg = SEG_LOW;
        end else if (g < GRAY_64) begin
            seg = SEG_MID;
        end else if (g < GRAY_192) begin
            seg = SEG_WIDE;
        end else begin
            seg = SEG_TOP;
        end
        case (seg)
            SEG_LOW: begin
                seg_start = 0;
                seg_len   = GRAY_32;
                r_lo      = ratio_now[IDX_RATIO_0];
                r_hi      = ratio_now[IDX_RATIO_32];
            end
            SEG_MID: begin
                seg_start = GRAY_32;
                seg_len   = longint'(GRAY_64) - longint'(GRAY_32);
                r_lo      = ratio_now[IDX_RATIO_32];
                r_hi      = ratio_now[IDX_RATIO_64];
            end
            SEG_WIDE: begin
                seg_start = GRAY_64;
                seg_len   = longint'(GRAY_192) - longint'(GRAY_64);
                r_lo      = ratio_now[IDX_RATIO_64];
                r_hi      = ratio_now[IDX_RATIO_192];
            end
            default: begin
                seg_start = GRAY_192;
                seg_len   = longint'(PIX_MAX) - longint'(GRAY_192);
                r_lo      = ratio_now[IDX_RATIO_192];
                r_hi      = ratio_now[IDX_RATIO_255];
            end
        endcase
        // interpolated ratio scaled by the segment length, then an exact divide
        num   = r_lo * seg_len + (gv - seg_start) * (r_hi - r_lo);
        total = gv + (num * gv) / (seg_len * CORR_DIV);
        if (total < 0) begin
            res.pixel   = '0;
            res.clamped = 1'b1;
        end else if (total > longint'(PIX_MAX)) begin
            res.pixel   = PIX_MAX;
            res.clamped = 1'b1;
        end else begin
            res.pixel   = t_pix'(total);
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    // one register write on the config port, mirrored into the shadow copy
    task automatic write_ratio(input t_idx idx, input t_ratio val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx < RATIO_N) begin
            ratio_now[idx] = val;
        end
    endtask

    task automatic finish_writes;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // wait until every request has gone in and every result has come out
    task automatic settle;
        while (pending_pixels.size() != 0 || i_valid || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_setting kind);
        t_ratio val;
        for (int i = 0; i < RATIO_N; i++) begin
            case (kind)
                SET_ALL_MAX:   val = RATIO_TOP;
                SET_ALL_MIN:   val = RATIO_BOTTOM;
                SET_ALTERNATE: val = (i % 2 == 0) ? RATIO_TOP : RATIO_BOTTOM;
                SET_GENTLE:    val = t_ratio'(int'($urandom_range(0, 192)) - 96);
                default:       val = t_ratio'($urandom_range(0, 1023));
            endcase
            // random settings leave some registers as they were
            if (kind == SET_ALL_MAX || kind == SET_ALL_MIN || kind == SET_ALTERNATE ||
                $urandom_range(0, 3) != 0) begin
                write_ratio(t_idx'(i), val);
            end
        end
        // now and then a write to an index past the last ratio, which must be dropped
        if ($urandom_range(0, 2) == 0) begin
            write_ratio(t_idx'($urandom_range(RATIO_N, IDX_LAST)),
                        t_ratio'($urandom_range(0, 1023)));
        end
        finish_writes();
    endtask

    // random pixel, biased a quarter of the time towards the segment boundaries
    function automatic t_pix pick_pixel();
        int base;
        int pix;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       base = 0;
                1:       base = GRAY_32;
                2:       base = GRAY_64;
                3:       base = GRAY_192;
                default: base = PIX_MAX;
            endcase
            pix = base + int'($urandom_range(0, 2)) - 1;
            if (pix < 0) begin
                pix = 0;
            end else if (pix > PIX_MAX) begin
                pix = PIX_MAX;
            end
            return t_pix'(pix);
        end
        return t_pix'($urandom_range(0, PIX_MAX));
    endfunction

    // sender: offers pending pixels in bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                i_pixel_in <= pending_pixels.pop_front();
                i_valid    <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of the bursts run straight on with no gap
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: its own stall pattern, plus long hold-offs counted here
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (results_seen >= next_hold_mark) begin
            // hold off long enough for the pipe to fill and stall the sender
            hold_left      = HOLD_LEN - 1;
            next_hold_mark = next_hold_mark + HOLD_STEP;
            i_stall <= 1'b1;
        end else begin
            if (rx_cycle % 48 == 0) begin
                drain_mode = t_drain'($urandom_range(0, 3));
            end
            case (drain_mode)
                DRAIN_LIGHT:  i_stall <= ($urandom_range(0, 7) == 0);
                DRAIN_HEAVY:  i_stall <= ($urandom_range(0, 1) == 1);
                DRAIN_TOGGLE: i_stall <= rx_cycle[1];
                default:      i_stall <= 1'b0;
            endcase
        end
    end

    // input and output sides sampled at the rising edge
    always @(posedge i_clk) begin
        t_compensated want;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            expected_pixels.push_back(compensate_pixel(i_pixel_in));
            accepted_count++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, actual pixel_out %0d clamped %0b",
                         $time, o_pixel_out, o_clamped);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (want.clamped && want.pixel == PIX_MAX) begin
                    clamp_high_seen++;
                end else if (want.clamped) begin
                    clamp_low_seen++;
                end
                if (o_pixel_out !== want.pixel) begin
                    $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                             $time, want.pixel, o_pixel_out);
                    error_count++;
                end
                if (o_clamped !== want.clamped) begin
                    $display("%0t: clamped mismatch, expected %0b, actual %0b",
                             $time, want.clamped, o_clamped);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        static t_pix reset_pixels  [3]  = '{8'd0, 8'd128, 8'd255};
        static t_pix corner_pixels [14] = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'd63, 8'd64,
                                     8'd65, 8'd127, 8'd191, 8'd192, 8'd193, 8'd254, 8'd255};
        t_setting kind;
        for (int i = 0; i < RATIO_N; i++) begin
            ratio_now[i] = '0;
        end

        // synchronous reset held, then released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ratios straight out of reset: output follows input, never clamped
        @(posedge i_clk);
        foreach (reset_pixels[i]) pending_pixels.push_back(reset_pixels[i]);
        settle();

        // alternating extremes, so both clamp directions show up at the breakpoints
        write_ratio(IDX_RATIO_0,   RATIO_BOTTOM);
        write_ratio(IDX_RATIO_32,  RATIO_TOP);
        write_ratio(IDX_RATIO_64,  RATIO_BOTTOM);
        write_ratio(IDX_RATIO_192, RATIO_TOP);
        write_ratio(IDX_RATIO_255, RATIO_BOTTOM);
        // writes past the last ratio must leave every register alone
        for (int k = RATIO_N; k <= IDX_LAST; k++) begin
            write_ratio(t_idx'(k), '0);
        end
        finish_writes();
        @(posedge i_clk);
        foreach (corner_pixels[i]) pending_pixels.push_back(corner_pixels[i]);
        settle();

        // every ratio at the top: a mid-gray pixel pushed past white
        apply_setting(SET_ALL_MAX);
        @(posedge i_clk);
        pending_pixels.push_back(8'd2);
        pending_pixels.push_back(8'd100);
        settle();

        // every ratio at the bottom: pulled below black
        apply_setting(SET_ALL_MIN);
        @(posedge i_clk);
        pending_pixels.push_back(8'd200);
        pending_pixels.push_back(8'd17);
        settle();

        // random phases, each under a fresh setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                2:       kind = SET_ALL_MAX;
                5:       kind = SET_ALL_MIN;
                8:       kind = SET_ALTERNATE;
                default: kind = ($urandom_range(0, 1) == 0) ? SET_GENTLE : SET_RANDOM;
            endcase
            apply_setting(kind);
            @(posedge i_clk);
            repeat (PHASE_ITEMS) pending_pixels.push_back(pick_pixel());
            settle();
        end

        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
            error_count++;
        end

        $display("%0d requests accepted and %0d results checked under %0d ratio settings",
                 accepted_count, results_seen, settings_used);
        $display("%0d results clamped at white, %0d at black, %0d errors",
                 clamp_high_seen, clamp_low_seen, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== gray_level_pixel_compensation.f =====
hdl/glpc_pkg.sv
hdl/gray_level_pixel_compensation.sv
tb/sv/tb_gray_level_pixel_compensation.sv
